>>> hw/rtl/lagged_fibonacci_range_rng_defines.svh
// Assertion macros for the checker file of the range generator
`ifndef LAGGED_FIBONACCI_RANGE_RNG_DEFINES_SVH
`define LAGGED_FIBONACCI_RANGE_RNG_DEFINES_SVH

// Same-cycle implication, gated off while rst is high
`define LFR_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lagged_fibonacci_range_rng: check failed");

// Next-cycle implication, gated off while rst is high
`define LFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lagged_fibonacci_range_rng: check failed");

`endif

>>> hw/rtl/lfr_pkg.sv
// Shared types, codes and helpers of the lagged Fibonacci range generator
`default_nettype none

package lfr_pkg;

  localparam int WORD_W     = 30;
  localparam int RAW_W      = 24;
  localparam int VAL_W      = 16;
  localparam int SPAN_W     = 17;
  localparam int NUM_W      = WORD_W - 12;
  localparam int RAW_SHIFT  = 6;
  localparam int MAX_TRIES  = 256;
  localparam int TRY_W      = $clog2(MAX_TRIES);
  localparam int CMDQ_DEPTH = 2;

  localparam logic [1:0] OP_RESEED = 2'd0;
  localparam logic [1:0] OP_RAW    = 2'd1;
  localparam logic [1:0] OP_RANGE  = 2'd2;

  typedef enum logic [1:0] {
    K_RESEED,
    K_RAW,
    K_RANGE,
    K_FIXED
  } cmd_kind_t;

  // lo doubles as the result of a fixed command
  typedef struct packed {
    cmd_kind_t            kind;
    logic [VAL_W-1:0]     lo;
    logic [SPAN_W-1:0]    span;
    logic [VAL_W-1:0]     mask;
  } cmd_t;

  // Smear the top set bit down: smallest all-ones mask covering v
  function automatic logic [VAL_W-1:0] smear16(input logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] m;
    m = v;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    return m;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lfr_channels.sv
// Valid/ready channel interfaces for requests and results
`default_nettype none

interface lfr_in_if
  import lfr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic signed [VAL_W-1:0] range_from;
  logic signed [VAL_W-1:0] range_to;

  modport source (output valid, opcode, range_from, range_to, input ready);
  modport sink   (input valid, opcode, range_from, range_to, output ready);
endinterface

interface lfr_out_if
  import lfr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [RAW_W-1:0]  raw_value;
  logic signed [VAL_W-1:0] ranged_value;

  modport source (output valid, raw_value, ranged_value, input ready);
  modport sink   (input valid, raw_value, ranged_value, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/lfr_ram.sv
// Generic RAM: one write port, two registered read ports
`default_nettype none

module lfr_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 55
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

>>> hw/rtl/lfr_front.sv
// Front end: takes requests, resolves trivial ranges, builds queue commands
`default_nettype none

module lfr_front
  import lfr_pkg::*;
(
  lfr_in_if.sink           in_ch,
  input  wire logic        q_full,
  output logic             push,
  output cmd_t             push_cmd
);

  logic signed [SPAN_W:0] span_s;
  logic [VAL_W-1:0]       span_m1;

  always_comb begin
    span_s  = (SPAN_W+1)'(in_ch.range_to) - (SPAN_W+1)'(in_ch.range_from) + (SPAN_W+1)'(1);
    span_m1 = VAL_W'(span_s - (SPAN_W+1)'(1));

    in_ch.ready = !q_full;
    push        = in_ch.valid && !q_full &&
                  (in_ch.opcode == OP_RESEED || in_ch.opcode == OP_RAW ||
                   in_ch.opcode == OP_RANGE);

    push_cmd.lo   = in_ch.range_from;
    push_cmd.span = span_s[SPAN_W-1:0];
    push_cmd.mask = smear16(span_m1);

    priority if (in_ch.opcode == OP_RESEED) begin
      push_cmd.kind = K_RESEED;
    end else if (in_ch.opcode == OP_RAW) begin
      push_cmd.kind = K_RAW;
    end else if (in_ch.range_from == '0 && in_ch.range_to == '0) begin
      push_cmd.kind = K_FIXED;
    end else if (span_s > (SPAN_W+1)'(1)) begin
      push_cmd.kind = K_RANGE;
    end else begin
      // empty or single span answers range_from
      push_cmd.kind = K_FIXED;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lfr_cmd_fifo.sv
// Short command queue between the front end and the generator back end
`default_nettype none

module lfr_cmd_fifo
  import lfr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire cmd_t  push_cmd,
  input  wire logic  pop,
  output logic       full,
  output logic       not_empty,
  output cmd_t       head
);

  localparam int PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             slots [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  always_comb begin
    full      = (count == CNT_W'(CMDQ_DEPTH));
    not_empty = (count != '0);
    head      = slots[rd_ptr];
    do_push   = push && !full;
    do_pop    = pop && not_empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        slots[wr_ptr] <= push_cmd;
        wr_ptr <= (wr_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lfr_back.sv
// Back end: ring fill, generator steps, rejection loop and result register
`default_nettype none

module lfr_back
  import lfr_pkg::*;
#(
  parameter int RING_LENGTH = 55,
  parameter int SHORT_LAG   = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] seed,
  input  wire logic        cmd_valid,
  input  wire cmd_t        cmd,
  output logic             cmd_pop,
  lfr_out_if.source        out_ch
);

  localparam int IDX_W = $clog2(RING_LENGTH);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(RING_LENGTH - 1);
  localparam logic [IDX_W-1:0] TAP_START = IDX_W'(RING_LENGTH - SHORT_LAG);

  typedef enum logic [1:0] {
    B_IDLE,
    B_FILL,
    B_READ,
    B_SUM
  } state_t;

  state_t             state;
  cmd_t               cur;
  logic [IDX_W-1:0]   w_idx;
  logic [IDX_W-1:0]   t_idx;
  logic [IDX_W-1:0]   fill_idx;
  logic [TRY_W-1:0]   tries;
  logic               seeded;
  logic [WORD_W-1:0]  p1;
  logic [WORD_W-1:0]  p2;

  logic [WORD_W-1:0]  rd_a;
  logic [WORD_W-1:0]  rd_b;
  logic [WORD_W-1:0]  word_a;
  logic [WORD_W-1:0]  word_b;
  logic [WORD_W:0]    sum_full;
  logic [WORD_W-1:0]  sum;
  logic [WORD_W:0]    fill_full;
  logic [WORD_W-1:0]  fill_word;
  logic [NUM_W-1:0]   num;
  logic               num_ok;
  logic               out_free;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;

  lfr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RING_LENGTH)
  ) u_ring (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (w_idx),
    .raddr_b (t_idx),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_comb begin
    out_free = !out_ch.valid || out_ch.ready;
    cmd_pop  = (state == B_IDLE) && cmd_valid && (cmd.kind == K_RESEED || out_free);

    // ring reads as all zeros until the first reseed has filled it
    word_a   = seeded ? rd_a : '0;
    word_b   = seeded ? rd_b : '0;
    sum_full = {1'b0, word_a} + {1'b0, word_b};
    sum      = sum_full[WORD_W-1:0];

    num    = sum[WORD_W-1:12] & NUM_W'(cur.mask);
    num_ok = NUM_W'(num) < NUM_W'(cur.span);

    fill_full = {1'b0, p1} + {1'b0, p2};
    if (fill_idx == '0) begin
      fill_word = seed[WORD_W-1:0];
    end else if (fill_idx == IDX_W'(1)) begin
      fill_word = WORD_W'(1);
    end else begin
      fill_word = fill_full[WORD_W-1:0];
    end

    ram_we    = (state == B_FILL) || (state == B_SUM);
    ram_waddr = (state == B_FILL) ? fill_idx : w_idx;
    ram_wdata = (state == B_FILL) ? fill_word : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      out_ch.valid <= 1'b0;
      w_idx        <= '0;
      t_idx        <= '0;
      fill_idx     <= '0;
      tries        <= '0;
      seeded       <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (cmd_pop) begin
            cur   <= cmd;
            tries <= '0;
            unique case (cmd.kind)
              K_RESEED: begin
                fill_idx <= '0;
                state    <= B_FILL;
              end
              K_RAW, K_RANGE: begin
                state <= B_READ;
              end
              K_FIXED: begin
                out_ch.valid        <= 1'b1;
                out_ch.raw_value    <= '0;
                out_ch.ranged_value <= cmd.lo;
              end
              default: begin
                state <= B_IDLE;
              end
            endcase
          end
        end
        B_FILL: begin
          p2 <= p1;
          p1 <= fill_word;
          if (fill_idx == IDX_LAST) begin
            w_idx  <= '0;
            t_idx  <= TAP_START;
            seeded <= 1'b1;
            state  <= B_IDLE;
          end else begin
            fill_idx <= fill_idx + IDX_W'(1);
          end
        end
        B_READ: begin
          state <= B_SUM;
        end
        B_SUM: begin
          w_idx <= (w_idx == IDX_LAST) ? '0 : w_idx + IDX_W'(1);
          t_idx <= (t_idx == IDX_LAST) ? '0 : t_idx + IDX_W'(1);
          state <= B_IDLE;
          if (cur.kind == K_RAW) begin
            out_ch.valid        <= 1'b1;
            out_ch.raw_value    <= sum[WORD_W-1:RAW_SHIFT];
            out_ch.ranged_value <= '0;
          end else if (num_ok) begin
            out_ch.valid        <= 1'b1;
            out_ch.raw_value    <= '0;
            out_ch.ranged_value <= cur.lo + num[VAL_W-1:0];
          end else if (tries == TRY_W'(MAX_TRIES - 1)) begin
            // give up after the last try and answer range_from
            out_ch.valid        <= 1'b1;
            out_ch.raw_value    <= '0;
            out_ch.ranged_value <= cur.lo;
          end else begin
            tries <= tries + TRY_W'(1);
            state <= B_READ;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lagged_fibonacci_range_rng.sv
// Top level: additive lagged Fibonacci generator with raw and range draws.
// A draw is queued, popped, read from the ring, added and written back; a
// rejected range try repeats the read and add (at most 256 tries). Trivial
// ranges are answered at the pop; a reseed refills the ring. A 2-entry command
// queue takes requests while the back end works through one command at a time.
// Reset: control, indices and seed register clear; the ring reads as zeros.
`default_nettype none

module lagged_fibonacci_range_rng
  import lfr_pkg::*;
#(
  parameter int RING_LENGTH = 55,
  parameter int SHORT_LAG   = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  lfr_in_if.sink           in_ch,
  lfr_out_if.source        out_ch
);

  logic [31:0] seed_value;
  logic        q_full;
  logic        q_push;
  cmd_t        q_push_cmd;
  logic        q_pop;
  logic        q_not_empty;
  cmd_t        q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value <= '0;
    end else if (cfg_wr_en) begin
      seed_value <= cfg_wr_data;
    end
  end

  lfr_front u_front (
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (q_push),
    .push_cmd (q_push_cmd)
  );

  lfr_cmd_fifo u_cmdq (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  lfr_back #(
    .RING_LENGTH (RING_LENGTH),
    .SHORT_LAG   (SHORT_LAG)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .seed      (seed_value),
    .cmd_valid (q_not_empty),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

>>> hw/rtl/lfr_checker.sv
// Port-level checks for the range generator, bound to the top level
`default_nettype none

`include "lagged_fibonacci_range_rng_defines.svh"

module lfr_checker
  import lfr_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [RAW_W-1:0]        raw_value,
  input wire logic signed [VAL_W-1:0] ranged_value
);

  // a stalled result holds until transfer
  `LFR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(raw_value) && $stable(ranged_value))

  // a result carries either a raw or a ranged value, never both
  `LFR_ASSERT_IMPL(a_out_excl, clk, rst, out_valid, raw_value == '0 || ranged_value == '0)

  // reset drops any pending result and empties the queue
  `LFR_ASSERT_NEXT(a_rst_out, clk, 1'b0, rst, !out_valid)
  `LFR_ASSERT_NEXT(a_rst_in, clk, 1'b0, rst, in_ready)

endmodule

bind lagged_fibonacci_range_rng lfr_checker u_lfr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .raw_value    (out_ch.raw_value),
  .ranged_value (out_ch.ranged_value)
);

`default_nettype wire

>>> tb/lfr_tb_pkg.sv
// Draw scoreboard for the lagged Fibonacci range generator testbench
`timescale 1ns / 100ps

package lfr_tb_pkg;
  import lfr_pkg::*;

  localparam int RING_WORDS  = 55;
  localparam int TAP_LAG     = 24;
  localparam int RANGE_SHIFT = 12;

  localparam logic [1:0] OP_RESERVED = 2'd3;

  typedef struct packed {
    logic [RAW_W-1:0]        raw;
    logic signed [VAL_W-1:0] ranged;
  } draw_result_t;

  class draw_scoreboard;
    logic [WORD_W-1:0] ring [RING_WORDS];
    int                wr_pos;
    int                tap_pos;
    logic [31:0]       seed;
    draw_result_t      pending_draws [$];
    int fail_count;
    int checked_count;
    int raw_count;
    int range_count;
    int reseed_count;
    int reject_count;

    function new();
      foreach (ring[k]) ring[k] = '0;
      wr_pos        = 0;
      tap_pos       = 0;
      seed          = '0;
      fail_count    = 0;
      checked_count = 0;
      raw_count     = 0;
      range_count   = 0;
      reseed_count  = 0;
      reject_count  = 0;
    endfunction

    function void load_seed(logic [31:0] v);
      seed = v;
    endfunction

    function int pending();
      return pending_draws.size();
    endfunction

    // One generator step: add the two tapped words, write back, advance both
    function logic [WORD_W-1:0] advance_ring();
      logic [WORD_W-1:0] sum;
      sum = ring[wr_pos] + ring[tap_pos];
      ring[wr_pos] = sum;
      wr_pos  = (wr_pos == RING_WORDS - 1) ? 0 : wr_pos + 1;
      tap_pos = (tap_pos == RING_WORDS - 1) ? 0 : tap_pos + 1;
      return sum;
    endfunction

    function void refill_ring();
      int k;
      ring[0] = seed[WORD_W-1:0];
      ring[1] = WORD_W'(1);
      for (k = 2; k < RING_WORDS; k++) ring[k] = ring[k-1] + ring[k-2];
      wr_pos  = 0;
      tap_pos = RING_WORDS - TAP_LAG;
    endfunction

    function void note_request(logic [1:0] op, logic signed [VAL_W-1:0] lo,
                               logic signed [VAL_W-1:0] hi);
      draw_result_t      exp_r;
      logic [WORD_W-1:0] sum;
      int lo_i, hi_i, span, pow, num, res, tries;
      bit hit;
      exp_r = '0;
      case (op)
        OP_RESEED: begin
          refill_ring();
          reseed_count++;
        end
        OP_RAW: begin
          sum = advance_ring();
          exp_r.raw = sum[WORD_W-1:RAW_SHIFT];
          pending_draws.push_back(exp_r);
          raw_count++;
        end
        OP_RANGE: begin
          lo_i = lo;
          hi_i = hi;
          span = hi_i - lo_i + 1;
          res  = lo_i;
          hit  = 1'b0;
          // 0..0 and empty or single spans take no generator step
          if (lo_i == 0 && hi_i == 0) begin
            res = 0;
          end else if (span > 1) begin
            pow = 2;
            while (pow < span) pow = pow << 1;
            for (tries = 0; tries < MAX_TRIES && !hit; tries++) begin
              sum = advance_ring();
              num = int'(sum[WORD_W-1:RANGE_SHIFT]) & (pow - 1);
              if (num < span) begin
                res = lo_i + num;
                hit = 1'b1;
              end else begin
                reject_count++;
              end
            end
          end
          exp_r.ranged = res[VAL_W-1:0];
          pending_draws.push_back(exp_r);
          range_count++;
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [RAW_W-1:0] raw, logic signed [VAL_W-1:0] ranged);
      draw_result_t exp_r;
      if (pending_draws.size() == 0) begin
        $error("unexpected result: raw_value=%0h ranged_value=%0d", raw, ranged);
        fail_count++;
      end else begin
        exp_r = pending_draws.pop_front();
        checked_count++;
        if (raw !== exp_r.raw) begin
          $error("raw_value: expected %0h, actual %0h", exp_r.raw, raw);
          fail_count++;
        end
        if (ranged !== exp_r.ranged) begin
          $error("ranged_value: expected %0d, actual %0d", exp_r.ranged, ranged);
          fail_count++;
        end
      end
    endfunction
  endclass

endpackage

>>> tb/tb_top.sv
// Top-level testbench of the lagged Fibonacci range generator
`timescale 1ns / 100ps

module tb_top;
  import lfr_pkg::*;
  import lfr_tb_pkg::*;

  localparam int SETTLE_CYCLES = 150;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic        quiet;

  lfr_in_if  req_ch ();
  lfr_out_if res_ch ();

  draw_scoreboard board;

  lagged_fibonacci_range_rng dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (req_ch),
    .out_ch      (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_request(input logic [1:0] op, input logic signed [VAL_W-1:0] lo,
                              input logic signed [VAL_W-1:0] hi);
    while (!quiet && $urandom_range(0, 99) < 15) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.opcode     <= op;
    req_ch.range_from <= lo;
    req_ch.range_to   <= hi;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    board.note_request(op, lo, hi);
  endtask

  task automatic send_random_request();
    int sel, lo_i, hi_i, w, k;
    sel = $urandom_range(0, 99);
    if (sel < 2) begin
      send_request(OP_RESEED, VAL_W'($urandom), VAL_W'($urandom));
    end else if (sel < 6) begin
      send_request(OP_RESERVED, VAL_W'($urandom), VAL_W'($urandom));
    end else if (sel < 50) begin
      send_request(OP_RAW, VAL_W'($urandom), VAL_W'($urandom));
    end else begin
      lo_i = int'($urandom_range(0, 65535)) - 32768;
      hi_i = int'($urandom_range(0, 65535)) - 32768;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          w = $urandom_range(1, 40);
          hi_i = lo_i + w - 1;
          if (hi_i > 32767) hi_i = 32767;
        end
        5: begin
          // span one past a power of two: heavy rejection
          k = $urandom_range(1, 14);
          lo_i = int'($urandom_range(0, 65535 - (1 << k))) - 32768;
          hi_i = lo_i + (1 << k);
        end
        6: ;
        7: hi_i = lo_i;
        8: begin
          if ($urandom_range(0, 1) == 0) begin
            lo_i = 0;
            hi_i = 0;
          end else begin
            hi_i = lo_i - int'($urandom_range(1, 100));
            if (hi_i < -32768) hi_i = -32768;
          end
        end
        default: begin
          lo_i = int'($urandom_range(0, 16384)) - 32768;
          hi_i = int'($urandom_range(16384, 32767));
        end
      endcase
      send_request(OP_RANGE, lo_i[VAL_W-1:0], hi_i[VAL_W-1:0]);
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Reseeds and reserved opcodes leave no result behind; let them finish first
  task automatic write_seed(input logic [31:0] v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.load_seed(v);
  endtask

  // Result side: check each transfer, stall at random unless quiet
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready)
        board.check_result(res_ch.raw_value, res_ch.ranged_value);
      res_ch.ready <= quiet || $urandom_range(0, 99) >= 15;
    end
  end

  initial begin
    #60_000_000;
    $display("lagged_fibonacci_range_rng test failed");
    $finish;
  end

  initial begin
    logic [31:0] seed;
    int          phase;
    int          n;
    board = new();
    quiet             <= 1'b0;
    rst               <= 1'b1;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.opcode     <= OP_RAW;
    req_ch.range_from <= '0;
    req_ch.range_to   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Draws on the cleared ring, then a reseed from the reset seed value
    send_request(OP_RAW, 16'sd0, 16'sd0);
    send_request(OP_RANGE, -16'sd5, 16'sd5);
    send_request(OP_RESERVED, 16'sd0, 16'sd0);
    send_request(OP_RESEED, 16'sd0, 16'sd0);
    send_request(OP_RAW, 16'sd0, 16'sd0);
    write_seed(32'hDEAD_BEEF);
    send_request(OP_RESEED, 16'sd0, 16'sd0);
    send_request(OP_RAW, 16'sd0, 16'sd0);
    send_request(OP_RAW, 16'sd0, 16'sd0);
    send_request(OP_RANGE, 16'sd0, 16'sd0);
    send_request(OP_RANGE, 16'sd10, 16'sd3);
    send_request(OP_RANGE, 16'sd7, 16'sd7);
    send_request(OP_RANGE, 16'sh7FFF, 16'sh8000);
    send_request(OP_RANGE, 16'sh8000, 16'sh7FFF);
    send_request(OP_RANGE, 16'sh8000, 16'sh8000);
    send_request(OP_RANGE, 16'sh7FFF, 16'sh7FFF);
    send_request(OP_RANGE, 16'sd0, 16'sd1);
    send_request(OP_RANGE, 16'sd0, 16'sd2);
    send_request(OP_RANGE, -16'sd1, 16'sd0);
    send_request(OP_RESERVED, 16'shFFFF, 16'shFFFF);
    send_request(OP_RAW, 16'shFFFF, 16'shFFFF);

    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       seed = 32'hFFFF_FFFF;
        1:       seed = 32'h0000_0000;
        2:       seed = 32'h3FFF_FFFF;
        3:       seed = 32'h4000_0000;
        default: seed = $urandom;
      endcase
      write_seed(seed);
      quiet <= (phase == 3);
      send_request(OP_RESEED, VAL_W'($urandom), VAL_W'($urandom));
      for (n = 0; n < 205; n++) begin
        if (phase == 2 && n == 100) wait_drained();
        send_random_request();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d results from %0d raw and %0d range draws (%0d rejected tries).",
             board.checked_count, board.raw_count, board.range_count, board.reject_count);
    $display("Ran %0d reseeds across 9 seed settings, from all zeros to all ones.",
             board.reseed_count);
    if (board.fail_count == 0 && board.pending() == 0)
      $display("lagged_fibonacci_range_rng test passed");
    else
      $display("lagged_fibonacci_range_rng test failed");
    $finish;
  end

endmodule
